// ===== hw/rtl/qmm_pkg.sv =====
// ----------------------------------------------------------------------------
// qmm_pkg
// Shared constants and types for the quad X motor mixer and pulse generator.
// ----------------------------------------------------------------------------
package qmm_pkg;

  // Motor and field geometry
  localparam int unsigned MOTOR_COUNT = 4;
  localparam int unsigned WIDTH_BITS  = 12;
  localparam int unsigned THROTTLE_W  = 12;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned YAW_W       = 12;
  localparam int unsigned GAIN_W      = 8;

  // Gain times angle: Q0.8 gain and 1/16 degree angle give a 2^12 divisor
  localparam int unsigned TERM_SHIFT  = 12;
  localparam int unsigned PROD_W      = GAIN_W + 1 + ANGLE_W;
  localparam int unsigned TERM_W      = PROD_W - TERM_SHIFT;

  // Mixing sum: throttle plus three signed terms, with headroom and sign
  localparam int unsigned SUM_W       = WIDTH_BITS + 4;

  // Quad X signs: a set bit subtracts that term for the motor
  localparam logic [MOTOR_COUNT-1:0] PITCH_NEG = 4'b1100;
  localparam logic [MOTOR_COUNT-1:0] ROLL_NEG  = 4'b1010;
  localparam logic [MOTOR_COUNT-1:0] YAW_NEG   = 4'b0110;

  // Request kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_ANGLE_GAIN = 1'b0;  // word index
  localparam logic [GAIN_W-1:0] ANGLE_GAIN_RESET = 8'd51;  // about 0.2

  typedef logic [WIDTH_BITS-1:0]  width_t;
  typedef logic [MOTOR_COUNT-1:0] level_t;

  localparam width_t WIDTH_MAX = '1;

  // Registered request after the gain multiply
  typedef struct packed {
    logic                         kind;
    logic [THROTTLE_W-1:0]        throttle;
    logic signed [TERM_W-1:0]     pitch_term;
    logic signed [TERM_W-1:0]     roll_term;
    logic signed [YAW_W-1:0]      yaw;
  } stage_t;

endpackage

// ===== hw/rtl/qmm_in_if.sv =====
// ----------------------------------------------------------------------------
// qmm_in_if
// Request channel: tick or frame start with throttle, angles and yaw.
// ----------------------------------------------------------------------------
interface qmm_in_if import qmm_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [THROTTLE_W-1:0]    throttle_width;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic signed [YAW_W-1:0]  yaw_term;

  modport source (
    output valid, kind, throttle_width, pitch_angle, roll_angle, yaw_term,
    input  ready
  );

  modport sink (
    input  valid, kind, throttle_width, pitch_angle, roll_angle, yaw_term,
    output ready
  );

endinterface

// ===== hw/rtl/qmm_out_if.sv =====
// ----------------------------------------------------------------------------
// qmm_out_if
// Result channel: motor output levels and busy flag.
// ----------------------------------------------------------------------------
interface qmm_out_if import qmm_pkg::*; ();

  logic   valid;
  logic   ready;
  level_t motor_levels;
  logic   busy_res;

  modport source (
    output valid, motor_levels, busy_res,
    input  ready
  );

  modport sink (
    input  valid, motor_levels, busy_res,
    output ready
  );

endinterface

// ===== hw/rtl/quad_motor_mixer_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// quad_motor_mixer_pulse_generator
// Quad X motor mixer with four microsecond pulse outputs.
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        kind, throttle_width, pitch_angle,
//                                    roll_angle, yaw_term
//   res_o    out  valid/ready        motor_levels, busy_res
//   apb      in   psel/penable       angle_gain at byte address 0
//
// One request per cycle sustained; the pipe is the input register with
// the gain multiply, then mix, pulse state update and result register.
// The pulse state is updated in the second stage, so each request sees the
// state left by the one before it.
// Reset is asynchronous, active low; no clearing pass is needed.
// A stalled result holds the whole pipe; in_i.ready drops only then.
// ----------------------------------------------------------------------------
module quad_motor_mixer_pulse_generator import qmm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  qmm_in_if.sink              in_i,
  qmm_out_if.source           res_o,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [PADDR_W-1:0]  paddr_i,
  input  logic [PDATA_W-1:0]  pwdata_i,
  output logic [PDATA_W-1:0]  prdata_o,
  output logic                pready_o
);

  logic [GAIN_W-1:0]        gain_q;
  logic                     advance;
  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s1_valid_q;
  stage_t                   s1_q;
  width_t [MOTOR_COUNT-1:0] mix_w;
  width_t [MOTOR_COUNT-1:0] widths_q, widths_d;
  width_t                   elapsed_q, elapsed_d;
  level_t                   levels_q, levels_d;
  logic                     res_valid_q;
  level_t                   res_levels_q;
  logic                     res_busy_q;

  // Configuration register
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_ANGLE_GAIN) ? PDATA_W'(gain_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= ANGLE_GAIN_RESET;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 paddr_i[2] == REG_ANGLE_GAIN) begin
      gain_q <= pwdata_i[GAIN_W-1:0];
    end
  end

  // Advance the pipe unless the result is stalled
  assign advance    = !res_valid_q || res_o.ready;
  assign in_i.ready = advance;

  // Gain times angle; the arithmetic shift gives floor division
  assign prod_p = $signed({1'b0, gain_q}) * in_i.pitch_angle;
  assign prod_r = $signed({1'b0, gain_q}) * in_i.roll_angle;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_i.valid) begin
      s1_q.kind       <= in_i.kind;
      s1_q.throttle   <= in_i.throttle_width;
      s1_q.pitch_term <= prod_p[PROD_W-1:TERM_SHIFT];
      s1_q.roll_term  <= prod_r[PROD_W-1:TERM_SHIFT];
      s1_q.yaw        <= in_i.yaw_term;
    end
  end

  qmm_mixer u_mixer (
    .term_i  (s1_q),
    .width_o (mix_w)
  );

  // Pulse state: load widths on a start while idle, count and drop outputs on ticks
  always_comb begin
    levels_d  = levels_q;
    elapsed_d = elapsed_q;
    widths_d  = widths_q;
    if (s1_valid_q && advance) begin
      if (s1_q.kind == KIND_START) begin
        if (levels_q == '0) begin
          widths_d  = mix_w;
          elapsed_d = '0;
          for (int i = 0; i < MOTOR_COUNT; i++) begin
            levels_d[i] = (mix_w[i] != '0);
          end
        end
      end else if (levels_q != '0) begin
        if (elapsed_q != WIDTH_MAX) begin
          elapsed_d = elapsed_q + 1'b1;
        end
        for (int i = 0; i < MOTOR_COUNT; i++) begin
          if (widths_q[i] <= elapsed_d) begin
            levels_d[i] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q  <= '0;
      elapsed_q <= '0;
      widths_q  <= '0;
    end else begin
      levels_q  <= levels_d;
      elapsed_q <= elapsed_d;
      widths_q  <= widths_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      res_levels_q <= levels_d;
      res_busy_q   <= (levels_d != '0);
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.motor_levels = res_levels_q;
  assign res_o.busy_res     = res_busy_q;

  // A tick never raises an output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && advance && s1_q.kind == KIND_TICK)
      |=> ((levels_q & ~$past(levels_q)) == '0))
    else $error("tick raised a motor output");

  // A start while busy leaves the widths alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && advance && s1_q.kind == KIND_START && levels_q != '0)
      |=> $stable(widths_q))
    else $error("start while busy changed widths");

  // Every request in the input stage reaches the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && advance) |=> res_valid_q)
    else $error("request lost between stages");

  // A motor with zero width is never high
  for (genvar g = 0; g < MOTOR_COUNT; g++) begin : g_zero_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      levels_q[g] |-> (widths_q[g] != '0))
      else $error("motor output high with zero width");
  end

endmodule

// ===== hw/rtl/qmm_mixer.sv =====
// ----------------------------------------------------------------------------
// qmm_mixer
// Quad X mix of throttle, pitch, roll and yaw, saturated to pulse widths.
// ----------------------------------------------------------------------------
module qmm_mixer import qmm_pkg::*; (
  input  stage_t                     term_i,
  output width_t [MOTOR_COUNT-1:0]   width_o
);

  logic signed [SUM_W-1:0] t_ext;
  logic signed [SUM_W-1:0] p_ext;
  logic signed [SUM_W-1:0] r_ext;
  logic signed [SUM_W-1:0] y_ext;
  logic signed [SUM_W-1:0] sum [MOTOR_COUNT];

  // Extend operands to the sum width
  assign t_ext = SUM_W'({1'b0, term_i.throttle});
  assign p_ext = SUM_W'(term_i.pitch_term);
  assign r_ext = SUM_W'(term_i.roll_term);
  assign y_ext = SUM_W'(term_i.yaw);

  // Mix with per-motor signs, then saturate to 0..WIDTH_MAX
  always_comb begin
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      sum[i] = t_ext
             + (PITCH_NEG[i] ? -p_ext : p_ext)
             + (ROLL_NEG[i]  ? -r_ext : r_ext)
             + (YAW_NEG[i]   ? -y_ext : y_ext);
      if (sum[i][SUM_W-1]) begin
        width_o[i] = '0;
      end else if (sum[i][SUM_W-2:WIDTH_BITS] != '0) begin
        width_o[i] = WIDTH_MAX;
      end else begin
        width_o[i] = sum[i][WIDTH_BITS-1:0];
      end
    end
  end

endmodule

// ===== bench/tb_quad_motor_mixer_pulse_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_motor_mixer_pulse_generator
// Self-checking bench for the quad X mixer and pulse generator.
//
// Drives frame starts and microsecond ticks through the request channel.
// A scoreboard class keeps its own copy of the mixer and pulse state, works
// out the levels and busy flag that each accepted request should return, and
// checks every result against them in order. The bench writes the angle gain
// over APB between phases, reads it back, and varies idling on both channels.
// ----------------------------------------------------------------------------
module tb_quad_motor_mixer_pulse_generator;
  import qmm_pkg::*;

  localparam realtime CLK_PERIOD     = 10ns;
  localparam int      RESET_CYCLES   = 10;
  localparam int      HOLD_CYCLES    = 250;
  localparam int      DRAIN_CYCLES   = 10;
  localparam int      TIMEOUT_CYCLES = 3_000_000;
  localparam int      PHASE_ITEMS    = 300;

  typedef struct packed {
    level_t levels;
    logic   busy;
  } pulse_result_t;

  // Scoreboard: mirror of the mixer and pulse state, plus the pending results
  class pulse_frame_tracker;
    logic [GAIN_W-1:0] gain;
    level_t            levels;
    width_t            elapsed;
    width_t            widths[MOTOR_COUNT];
    pulse_result_t     expected_q[$];
    int                failures;

    function new();
      gain     = ANGLE_GAIN_RESET;
      levels   = '0;
      elapsed  = '0;
      failures = 0;
      foreach (widths[i]) widths[i] = '0;
    endfunction

    function void log_mismatch(string what);
      failures++;
      if (failures <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function width_t clamp_width(int v);
      if (v < 0) return '0;
      if (v > int'(WIDTH_MAX)) return WIDTH_MAX;
      return width_t'(v);
    endfunction

    function bit busy_now();
      return levels != '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the pulse state for one accepted request and queue its result
    function void note_request(logic kind, logic [THROTTLE_W-1:0] thr,
                               logic signed [ANGLE_W-1:0] pitch,
                               logic signed [ANGLE_W-1:0] roll,
                               logic signed [YAW_W-1:0] yaw);
      int            t, p, r, y;
      pulse_result_t res;
      if (kind == KIND_START) begin
        // Start while busy is dropped without touching the state
        if (levels == '0) begin
          t = int'(thr);
          y = int'(yaw);
          // Floor division by 4096 through the arithmetic shift
          p = (int'(gain) * int'(pitch)) >>> TERM_SHIFT;
          r = (int'(gain) * int'(roll)) >>> TERM_SHIFT;
          widths[0] = clamp_width(t + p + r + y);
          widths[1] = clamp_width(t + p - r - y);
          widths[2] = clamp_width(t - p + r - y);
          widths[3] = clamp_width(t - p - r + y);
          foreach (widths[i]) levels[i] = (widths[i] != '0);
          elapsed = '0;
        end
      end else if (levels != '0) begin
        // Count saturates at the largest width
        if (elapsed != WIDTH_MAX) elapsed = elapsed + 1'b1;
        foreach (widths[i]) if (widths[i] <= elapsed) levels[i] = 1'b0;
      end
      res.levels = levels;
      res.busy   = (levels != '0);
      expected_q.push_back(res);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(level_t got_levels, logic got_busy);
      pulse_result_t exp_res;
      if (expected_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result levels %b busy %b", got_levels, got_busy));
        return;
      end
      exp_res = expected_q.pop_front();
      if (got_levels !== exp_res.levels)
        log_mismatch($sformatf("motor_levels expected %b got %b", exp_res.levels, got_levels));
      if (got_busy !== exp_res.busy)
        log_mismatch($sformatf("busy_res expected %b got %b", exp_res.busy, got_busy));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic               pready;

  qmm_in_if  in_if ();
  qmm_out_if res_if ();

  pulse_frame_tracker tracker;
  int items_sent;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_req       = 1'b0;

  quad_motor_mixer_pulse_generator dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_if),
    .res_o     (res_if),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      tracker.check_result(res_if.motor_levels, res_if.busy_res);
  end

  // Result sink: random stalls, or one long counted hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // Hold one request until accepted, then maybe drop valid and idle
  task automatic send_request(input logic kind, input logic [THROTTLE_W-1:0] thr,
                              input logic signed [ANGLE_W-1:0] pitch,
                              input logic signed [ANGLE_W-1:0] roll,
                              input logic signed [YAW_W-1:0] yaw);
    in_if.valid          <= 1'b1;
    in_if.kind           <= kind;
    in_if.throttle_width <= thr;
    in_if.pitch_angle    <= pitch;
    in_if.roll_angle     <= roll;
    in_if.yaw_term       <= yaw;
    do @(posedge clk); while (!in_if.ready);
    tracker.note_request(kind, thr, pitch, roll, yaw);
    items_sent++;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Request of the given kind with random payload
  task automatic send_noise(input logic kind);
    send_request(kind, THROTTLE_W'($urandom), ANGLE_W'($urandom), ANGLE_W'($urandom),
                 YAW_W'($urandom));
  endtask

  // Start a frame, then tick until every output has dropped
  task automatic run_frame(input logic [THROTTLE_W-1:0] thr,
                           input logic signed [ANGLE_W-1:0] pitch,
                           input logic signed [ANGLE_W-1:0] roll,
                           input logic signed [YAW_W-1:0] yaw,
                           input int ignored_start_pct);
    send_request(KIND_START, thr, pitch, roll, yaw);
    while (tracker.busy_now()) begin
      if ($urandom_range(0, 99) < ignored_start_pct) send_noise(KIND_START);
      else send_noise(KIND_TICK);
    end
  endtask

  // Stop offering and wait for every pending result
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Write the gain over APB, read it back, and mirror it in the scoreboard
  task automatic write_angle_gain(input logic [GAIN_W-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ANGLE_GAIN, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.gain = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(value))
      tracker.log_mismatch($sformatf("angle_gain readback expected %0d got %0d", value, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One wider frame with random content, then short frames with idle ticks
  task automatic run_random_phase(input int n_items);
    int first, a, b, c;
    first = items_sent;
    a = $urandom_range(0, 2000);
    b = $urandom_range(0, 2000);
    c = $urandom_range(0, 64);
    run_frame(THROTTLE_W'($urandom_range(0, 127)), ANGLE_W'(a - 1000), ANGLE_W'(b - 1000),
              YAW_W'(c - 32), 5);
    wait_drained();
    while (items_sent - first < n_items) begin
      a = $urandom_range(0, 400);
      b = $urandom_range(0, 400);
      c = $urandom_range(0, 16);
      run_frame(THROTTLE_W'($urandom_range(0, 24)), ANGLE_W'(a - 200), ANGLE_W'(b - 200),
                YAW_W'(c - 8), 8);
      repeat ($urandom_range(0, 2)) send_noise(KIND_TICK);
    end
  endtask

  initial begin
    tracker              = new();
    items_sent           = 0;
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_if.valid          = 1'b0;
    in_if.kind           = KIND_TICK;
    in_if.throttle_width = '0;
    in_if.pitch_angle    = '0;
    in_if.roll_angle     = '0;
    in_if.yaw_term       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset gain, no idling
    send_request(KIND_TICK, '0, '0, '0, '0);
    run_frame(12'd0, 16'sd0, 16'sd0, 12'sd0, 0);
    send_request(KIND_TICK, '1, '1, '1, '1);
    run_frame(12'd3, 16'sd0, 16'sd0, 12'sd0, 0);
    run_frame(12'd5, 16'sd16, -16'sd16, 12'sd1, 30);
    repeat (3) send_noise(KIND_TICK);
    run_frame(12'd20, 16'sd300, -16'sd300, -12'sd4, 0);
    run_frame(12'd2, -16'sd400, 16'sd0, 12'sd6, 0);

    // Gain extremes and mid values under each idling pattern
    write_angle_gain(8'd0);
    hold_req = 1'b1;
    run_random_phase(PHASE_ITEMS);

    write_angle_gain(8'd255);
    src_idle_pct = 66;
    run_random_phase(PHASE_ITEMS);

    write_angle_gain(GAIN_W'($urandom_range(2, 253)));
    src_idle_pct   = 0;
    sink_stall_pct = 66;
    run_random_phase(PHASE_ITEMS);

    // Full-scale angles stay short at the smallest nonzero gain
    write_angle_gain(8'd1);
    src_idle_pct   = 15;
    sink_stall_pct = 15;
    run_frame(12'd0, 16'sh8000, 16'sh7FFF, 12'sd0, 0);
    run_frame(12'd4, 16'sh7FFF, 16'sh8000, -12'sd3, 0);
    run_random_phase(PHASE_ITEMS);

    write_angle_gain(8'd128);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    run_random_phase(PHASE_ITEMS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results pending", tracker.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
